FILE: sv/pgfs_pkg.sv
`default_nettype none
package pgfs_pkg;

  // fixed field widths
  localparam int PART_W  = 11;
  localparam int GRID_W  = 16;
  localparam int COST_W  = 44;

  // parameter defaults
  localparam int MAX_PARTS_DEF = 1024;
  localparam int GRID_BITS_DEF = 16;

  typedef struct packed {
    logic [GRID_W-1:0] grid_x;
    logic [GRID_W-1:0] grid_y;
    logic [GRID_W-1:0] grid_z;
    logic [PART_W-1:0] part_count;
  } item_t;

  typedef struct packed {
    logic [PART_W-1:0] best_x;
    logic [PART_W-1:0] best_y;
    logic [PART_W-1:0] best_z;
    logic [COST_W-1:0] min_cost;
    logic              failed;
  } result_t;

  // which grid face product is involved
  typedef enum logic [1:0] {
    SEL_YZ,
    SEL_ZX,
    SEL_XY
  } face_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic {
    DIV_OUTER,
    DIV_INNER
  } div_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_GRID_YZ,
    ST_GRID_ZX,
    ST_GRID_XY,
    ST_OUTER_DIV,
    ST_OUTER_WAIT,
    ST_INNER_DIV,
    ST_INNER_WAIT,
    ST_COST0,
    ST_COST1,
    ST_COST2,
    ST_COST3,
    ST_UPDATE,
    ST_NEXT_PY,
    ST_NEXT_PX,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic      load_in;
    logic      grid_mul;
    logic      cost_mul;
    face_sel_t sel;
    acc_op_t   acc_op;
    logic      px_init;
    logic      px_inc;
    logic      py_init;
    logic      py_inc;
    logic      div_start;
    div_sel_t  div_sel;
    logic      take_rest;
    logic      take_pz;
    logic      update_best;
    logic      load_out;
  } cmd_t;

  typedef struct packed {
    logic n_ok;
    logic div_busy;
    logic rem_zero;
    logic px_last;
    logic py_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

FILE: sv/pgfs_div.sv
`default_nettype none
module pgfs_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [pgfs_pkg::PART_W-1:0] dividend,
  input  wire logic [pgfs_pkg::PART_W-1:0] divisor,
  output logic                           busy,
  output logic [pgfs_pkg::PART_W-1:0]    quot,
  output logic [pgfs_pkg::PART_W-1:0]    rem
);
  import pgfs_pkg::*;

  localparam int CNT_W = $clog2(PART_W + 1);

  logic [CNT_W-1:0]  cnt;
  logic [PART_W-1:0] dvs;
  logic [PART_W:0]   trial;
  logic              fits;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quot[PART_W-1]};
  assign fits  = trial >= {1'b0, dvs};
  assign busy  = cnt != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(PART_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvs  <= divisor;
      quot <= dividend;
      rem  <= '0;
    end else if (busy) begin
      quot <= {quot[PART_W-2:0], fits};
      if (fits) begin
        rem <= PART_W'(trial - {1'b0, dvs});
      end else begin
        rem <= trial[PART_W-1:0];
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/pgfs_datapath.sv
`default_nettype none
module pgfs_datapath #(
  parameter int MAX_PARTS = pgfs_pkg::MAX_PARTS_DEF,
  parameter int GRID_BITS = pgfs_pkg::GRID_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire pgfs_pkg::cmd_t    cmd,
  output pgfs_pkg::status_t      status,
  input  wire pgfs_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output pgfs_pkg::result_t      result
);
  import pgfs_pkg::*;

  localparam int G2 = 2 * GRID_BITS;
  localparam int PW = PART_W + G2;

  logic [GRID_BITS-1:0] gx, gy, gz;
  logic [PART_W-1:0]    n, px, py, rest, pz;
  logic [G2-1:0]        pyz, pzx, pxy;
  logic [G2-1:0]        grid_prod;
  logic [PART_W-1:0]    cost_a;
  logic [G2-1:0]        cost_b;
  logic [PW-1:0]        cost_prod;
  logic [COST_W-1:0]    prod, acc;
  logic                 have;
  logic [PART_W-1:0]    bx, by, bz;
  logic [COST_W-1:0]    bcost;
  logic [PART_W-1:0]    div_dividend, div_divisor, div_quot, div_rem;
  logic                 div_busy;

  // shared iterative divider
  assign div_dividend = (cmd.div_sel == DIV_OUTER) ? n : rest;
  assign div_divisor  = (cmd.div_sel == DIV_OUTER) ? px : py;

  pgfs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // status back to the controller
  assign status.n_ok     = (n != '0) && (32'(n) <= 32'(MAX_PARTS));
  assign status.div_busy = div_busy;
  assign status.rem_zero = div_rem == '0;
  assign status.px_last  = px == n;
  assign status.py_last  = py == rest;
  assign status.out_free = !result_valid || result_ready;

  // operand selection for the grid face and cost multipliers
  always_comb begin
    case (cmd.sel)
      SEL_YZ: begin
        grid_prod = G2'(gy) * G2'(gz);
        cost_a    = px - 1'b1;
        cost_b    = pyz;
      end
      SEL_ZX: begin
        grid_prod = G2'(gz) * G2'(gx);
        cost_a    = py - 1'b1;
        cost_b    = pzx;
      end
      SEL_XY: begin
        grid_prod = G2'(gx) * G2'(gy);
        cost_a    = pz - 1'b1;
        cost_b    = pxy;
      end
      default: begin
        grid_prod = '0;
        cost_a    = '0;
        cost_b    = '0;
      end
    endcase
  end

  assign cost_prod = PW'(cost_a) * PW'(cost_b);

  // search registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      gx <= item.grid_x[GRID_BITS-1:0];
      gy <= item.grid_y[GRID_BITS-1:0];
      gz <= item.grid_z[GRID_BITS-1:0];
      n  <= item.part_count;
    end
    if (cmd.grid_mul) begin
      case (cmd.sel)
        SEL_YZ:  pyz <= grid_prod;
        SEL_ZX:  pzx <= grid_prod;
        SEL_XY:  pxy <= grid_prod;
        default: pxy <= grid_prod;
      endcase
    end
    if (cmd.cost_mul) begin
      prod <= COST_W'(cost_prod);
    end
    case (cmd.acc_op)
      ACC_LOAD: acc <= prod;
      ACC_ADD:  acc <= acc + prod;
      default:  acc <= acc;
    endcase
    if (cmd.px_init) begin
      px <= PART_W'(1);
    end else if (cmd.px_inc) begin
      px <= px + 1'b1;
    end
    if (cmd.py_init) begin
      py <= PART_W'(1);
    end else if (cmd.py_inc) begin
      py <= py + 1'b1;
    end
    if (cmd.take_rest) begin
      rest <= div_quot;
    end
    if (cmd.take_pz) begin
      pz <= div_quot;
    end
    if (cmd.update_best && (!have || acc < bcost)) begin
      bx    <= px;
      by    <= py;
      bz    <= pz;
      bcost <= acc;
    end
  end

  // best split found flag
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (cmd.load_in) begin
      have <= 1'b0;
    end else if (cmd.update_best) begin
      have <= 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (have) begin
        result.best_x   <= bx;
        result.best_y   <= by;
        result.best_z   <= bz;
        result.min_cost <= bcost;
        result.failed   <= 1'b0;
      end else begin
        result.best_x   <= '0;
        result.best_y   <= '0;
        result.best_z   <= '0;
        result.min_cost <= '0;
        result.failed   <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: sv/pgfs_ctrl.sv
`default_nettype none
module pgfs_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire pgfs_pkg::status_t status,
  output pgfs_pkg::cmd_t         cmd
);
  import pgfs_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.sel    = SEL_YZ;
    cmd.acc_op = ACC_HOLD;
    cmd.div_sel = DIV_OUTER;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_next = status.n_ok ? ST_GRID_YZ : ST_FINISH;
      end
      ST_GRID_YZ: begin
        cmd.grid_mul = 1'b1;
        cmd.sel      = SEL_YZ;
        state_next   = ST_GRID_ZX;
      end
      ST_GRID_ZX: begin
        cmd.grid_mul = 1'b1;
        cmd.sel      = SEL_ZX;
        state_next   = ST_GRID_XY;
      end
      ST_GRID_XY: begin
        cmd.grid_mul = 1'b1;
        cmd.sel      = SEL_XY;
        cmd.px_init  = 1'b1;
        state_next   = ST_OUTER_DIV;
      end
      // n / px
      ST_OUTER_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_OUTER;
        state_next    = ST_OUTER_WAIT;
      end
      ST_OUTER_WAIT: begin
        if (!status.div_busy) begin
          if (status.rem_zero) begin
            cmd.take_rest = 1'b1;
            cmd.py_init   = 1'b1;
            state_next    = ST_INNER_DIV;
          end else begin
            state_next = ST_NEXT_PX;
          end
        end
      end
      // rest / py
      ST_INNER_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_INNER;
        state_next    = ST_INNER_WAIT;
      end
      ST_INNER_WAIT: begin
        cmd.div_sel = DIV_INNER;
        if (!status.div_busy) begin
          if (status.rem_zero) begin
            cmd.take_pz = 1'b1;
            state_next  = ST_COST0;
          end else begin
            state_next = ST_NEXT_PY;
          end
        end
      end
      // cut surface, one face term per cycle
      ST_COST0: begin
        cmd.cost_mul = 1'b1;
        cmd.sel      = SEL_YZ;
        state_next   = ST_COST1;
      end
      ST_COST1: begin
        cmd.cost_mul = 1'b1;
        cmd.sel      = SEL_ZX;
        cmd.acc_op   = ACC_LOAD;
        state_next   = ST_COST2;
      end
      ST_COST2: begin
        cmd.cost_mul = 1'b1;
        cmd.sel      = SEL_XY;
        cmd.acc_op   = ACC_ADD;
        state_next   = ST_COST3;
      end
      ST_COST3: begin
        cmd.acc_op = ACC_ADD;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update_best = 1'b1;
        state_next      = ST_NEXT_PY;
      end
      ST_NEXT_PY: begin
        if (status.py_last) begin
          state_next = ST_NEXT_PX;
        end else begin
          cmd.py_inc = 1'b1;
          state_next = ST_INNER_DIV;
        end
      end
      ST_NEXT_PX: begin
        if (status.px_last) begin
          state_next = ST_FINISH;
        end else begin
          cmd.px_inc = 1'b1;
          state_next = ST_OUTER_DIV;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/process_grid_factor_search.sv
// search time depends on n: the shared divider runs once per px and once per py tried;
// a zero or oversized count skips the search and goes straight to the result
// throughput: one word at a time; the next word is taken once the result is in the
// output register, which holds it until it is taken
// reset: synchronous active-high rst returns the controller to idle, no result pending
`default_nettype none
module process_grid_factor_search #(
  parameter int MAX_PARTS = pgfs_pkg::MAX_PARTS_DEF,
  parameter int GRID_BITS = pgfs_pkg::GRID_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_ready,
  input  wire pgfs_pkg::item_t   item,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output pgfs_pkg::result_t      result
);
  import pgfs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // search sequencer
  pgfs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // divider, multipliers and best-split registers
  pgfs_datapath #(
    .MAX_PARTS (MAX_PARTS),
    .GRID_BITS (GRID_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire
